/* hdl/siphash_2_4_engine_defines.svh */
// Assertion macros shared by the SipHash-2-4 engine RTL.
// Needs clk and arst_n in the scope of every use.
`ifndef SIPHASH_2_4_ENGINE_DEFINES_SVH
`define SIPHASH_2_4_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SIP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("siphash engine: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SIP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("siphash engine: next-cycle check failed");

`endif

/* hdl/sip_pkg.sv */
// Shared types, constants and helpers for the SipHash-2-4 engine.
// No dependencies; imported by every module of the engine.
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

	// initialisation vectors
	localparam logic [63:0] SIP_IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_IV3 = 64'h7465646279746573;

	localparam logic [63:0] SIP_FINAL_XOR = 64'h0000_0000_0000_00ff;
	localparam int SIP_LEN_SHIFT = 56;
	localparam logic [3:0] SIP_WORD_BYTES = 4'd8;

	// register indexes (paddr bit 3)
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	// four-lane chaining state
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} sip_state_t;

	// key write strobe handed from the register block to the core
	typedef struct packed {
		logic        wr_low;
		logic        wr_high;
		logic [63:0] wdata;
	} sip_cfg_wr_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABS,
		ST_FIN
	} sip_fsm_t;

	// chaining state loaded from a key
	function automatic sip_state_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
		sip_state_t s;
		s.a = k0 ^ SIP_IV0;
		s.b = k1 ^ SIP_IV1;
		s.c = k0 ^ SIP_IV2;
		s.d = k1 ^ SIP_IV3;
		return s;
	endfunction

endpackage

`default_nettype wire

/* hdl/siphash_2_4_engine.sv */
// Top level of the SipHash-2-4 engine: stream ports, key registers, core.
// Depends on sip_pkg, sip_cfg, sip_core (and through it sip_round).
`timescale 1ns / 1ps
`default_nettype none

// Keyed SipHash-2-4 over a stream of 64-bit little-endian words. Load the
// 128-bit key through the APB port (key_low at 0x0, key_high at 0x8); a key
// written between messages takes effect at once, one written mid-message at
// the next message. Each word is taken while the core is idle and then runs
// through a single shared SipRound unit, one round per cycle, with s_tready
// low meanwhile: a non-final word gets two rounds. A final word with 0 to 7
// bytes gets two tail rounds and four finalisation rounds; a full 8-byte final
// word gets its own two rounds first, as its tail adds two rounds. The hash
// goes to an output register, so the next message may start while it waits;
// only a second hash finishing before the first is taken stalls the last
// round. Byte counts above eight count as eight, and short non-final words
// are absorbed whole.
module siphash_2_4_engine
	import sip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// message words in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
	input  logic        s_tlast,   // last_word
	// hash out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [63:0] hash_value
);

	logic [63:0] key_low, key_high;
	sip_cfg_wr_t cfg_wr;

	sip_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_low  (key_low),
		.key_high (key_high),
		.cfg_wr   (cfg_wr)
	);

	sip_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_low   (key_low),
		.key_high  (key_high),
		.cfg_wr    (cfg_wr),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_word   (s_tdata[63:0]),
		.in_count  (s_tdata[67:64]),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hash  (m_tdata)
	);

endmodule

`default_nettype wire

/* hdl/sip_round.sv */
// One SipRound over the four chaining lanes, purely combinational.
// Depends on sip_pkg for the state type.
`timescale 1ns / 1ps
`default_nettype none

module sip_round
	import sip_pkg::*;
(
	input  sip_state_t state_in,
	output sip_state_t state_out
);

	logic [63:0] a1, b1, c1, d1;
	logic [63:0] a2, b2, c2, d2;

	// first half: add, rotate, mix
	always_comb begin
		a1 = state_in.a + state_in.b;
		b1 = {state_in.b[50:0], state_in.b[63:51]} ^ a1;
		c1 = state_in.c + state_in.d;
		d1 = {state_in.d[47:0], state_in.d[63:48]} ^ c1;
	end

	// second half: cross the lanes
	always_comb begin
		a2 = {a1[31:0], a1[63:32]} + d1;
		d2 = {d1[42:0], d1[63:43]} ^ a2;
		c2 = c1 + b1;
		b2 = {b1[46:0], b1[63:47]} ^ c2;
	end

	assign state_out.a = a2;
	assign state_out.b = b2;
	assign state_out.c = {c2[31:0], c2[63:32]};
	assign state_out.d = d2;

endmodule

`default_nettype wire

/* hdl/sip_cfg.sv */
// APB-style key registers of the SipHash-2-4 engine.
// Depends on sip_pkg for the write strobe struct and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module sip_cfg
	import sip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output logic [63:0] key_low,
	output logic [63:0] key_high,
	output sip_cfg_wr_t cfg_wr
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// decode the write strobe
	always_comb begin
		cfg_wr.wr_low  = wr_en & (paddr[3] == REG_KEY_LOW);
		cfg_wr.wr_high = wr_en & (paddr[3] == REG_KEY_HIGH);
		cfg_wr.wdata   = pwdata;
	end

	// hold the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else begin
			if (cfg_wr.wr_low) begin
				key_low_q <= pwdata;
			end
			if (cfg_wr.wr_high) begin
				key_high_q <= pwdata;
			end
		end
	end

	// read back
	assign prdata   = (paddr[3] == REG_KEY_HIGH) ? key_high_q : key_low_q;
	assign key_low  = key_low_q;
	assign key_high = key_high_q;

endmodule

`default_nettype wire

/* hdl/sip_core.sv */
// Sequencer, chaining state and output register of the SipHash-2-4 engine.
// Depends on sip_pkg, sip_round and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "siphash_2_4_engine_defines.svh"

module sip_core
	import sip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  sip_cfg_wr_t cfg_wr,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] in_word,
	input  logic [3:0]  in_count,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_hash
);

	sip_fsm_t    state_q, state_d;
	logic [1:0]  rcnt_q, rcnt_d;
	sip_state_t  chain_q, chain_d, rnd;
	logic [63:0] w_q, tail_q;
	logic        two_q, fin_q, mid_q;
	logic [7:0]  len_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic        in_accept, out_free, fin_last, fin_done, cfg_reload;
	logic [3:0]  cnt_sat;
	logic        full;
	logic [7:0]  len_new;
	logic [63:0] masked, tail_word, first_w;
	logic [63:0] key_low_eff, key_high_eff;

	sip_round u_round (
		.state_in  (chain_q),
		.state_out (rnd)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign fin_last  = (state_q == ST_FIN) && (rcnt_q == 2'd3);
	assign fin_done  = fin_last && out_free;

	// key as it stands after a write in this cycle
	assign key_low_eff  = cfg_wr.wr_low  ? cfg_wr.wdata : key_low;
	assign key_high_eff = cfg_wr.wr_high ? cfg_wr.wdata : key_high;
	assign cfg_reload   = (cfg_wr.wr_low | cfg_wr.wr_high) & ~mid_q
		& (state_q == ST_IDLE) & ~in_accept;

	// form the word to absorb and the tail word
	always_comb begin
		cnt_sat = (in_count > SIP_WORD_BYTES) ? SIP_WORD_BYTES : in_count;
		full    = ~in_last | (cnt_sat == SIP_WORD_BYTES);
		len_new = len_q + (full ? {4'd0, SIP_WORD_BYTES} : {4'd0, cnt_sat});
		for (int i = 0; i < 8; i++) begin
			masked[i*8 +: 8] = (!full && (4'(i) < cnt_sat)) ? in_word[i*8 +: 8] : 8'h00;
		end
		tail_word = masked | ({56'd0, len_new} << SIP_LEN_SHIFT);
		first_w   = full ? in_word : tail_word;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS: begin
				if (rcnt_q == 2'd1) begin
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (!two_q) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (fin_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls: chaining state and round count
	always_comb begin
		chain_d = chain_q;
		rcnt_d  = rcnt_q;
		case (state_q)
			ST_IDLE: begin
				rcnt_d = 2'd0;
				if (in_accept) begin
					chain_d.d = chain_q.d ^ first_w;
				end else if (cfg_reload) begin
					chain_d = sip_init(key_low_eff, key_high_eff);
				end
			end
			ST_ABS: begin
				chain_d = rnd;
				if (rcnt_q == 2'd1) begin
					rcnt_d    = 2'd0;
					chain_d.a = rnd.a ^ w_q;
					if (fin_q && two_q) begin
						chain_d.d = rnd.d ^ tail_q;
					end else if (fin_q) begin
						chain_d.c = rnd.c ^ SIP_FINAL_XOR;
					end
				end else begin
					rcnt_d = rcnt_q + 2'd1;
				end
			end
			ST_FIN: begin
				if (rcnt_q != 2'd3) begin
					chain_d = rnd;
					rcnt_d  = rcnt_q + 2'd1;
				end else if (out_free) begin
					chain_d = sip_init(key_low_eff, key_high_eff);
					rcnt_d  = 2'd0;
				end
			end
			default: begin
				chain_d = chain_q;
				rcnt_d  = 2'd0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rcnt_q      <= 2'd0;
			chain_q     <= sip_init(64'd0, 64'd0);
			len_q       <= 8'd0;
			mid_q       <= 1'b0;
			two_q       <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rcnt_q  <= rcnt_d;
			chain_q <= chain_d;
			if (in_accept) begin
				len_q <= len_new;
				mid_q <= mid_q | ~in_last;
				two_q <= in_last & full;
				fin_q <= in_last;
			end else if (state_q == ST_ABS && rcnt_q == 2'd1 && fin_q && two_q) begin
				two_q <= 1'b0;
			end
			if (fin_done) begin
				len_q <= 8'd0;
				mid_q <= 1'b0;
				fin_q <= 1'b0;
			end
			// drop the word once taken, raise it when a hash is done
			if (fin_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			w_q    <= first_w;
			tail_q <= tail_word;
		end else if (state_q == ST_ABS && rcnt_q == 2'd1 && fin_q && two_q) begin
			w_q <= tail_q;
		end
		if (fin_done) begin
			hash_q <= rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hash  = hash_q;

	`SIP_ASSERT_NXT(a_accept_busy, in_accept, state_q != ST_IDLE)
	`SIP_ASSERT_NXT(a_fin_stall, fin_last && !out_free, (state_q == ST_FIN) && out_valid_q)
	`SIP_ASSERT_IMP(a_len_whole, mid_q && (state_q == ST_IDLE), len_q[2:0] == 3'd0)
	`SIP_ASSERT_IMP(a_fin_single, state_q == ST_FIN, fin_q && !two_q)

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for siphash_2_4_engine: keyed hashes of streamed messages.
// A built-in SipHash-2-4 predictor checks every hash; needs sip_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
	import sip_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int BATCH_WORDS   = 225;

	typedef struct {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} msg_word_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [63:0] pwdata   = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;  // [63:0] data_word, [67:64] byte_count, [71:68] zero
	logic        s_tlast  = 1'b0; // last_word
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;         // [63:0] hash_value

	// stimulus and expectations
	msg_word_t   pending_words[$];
	msg_word_t   next_word;
	logic [63:0] hashes_due[$];
	int          send_idle_pct = 10;
	int          recv_idle_pct = 45;
	int          mismatches    = 0;

	// predictor state
	sip_state_t  lanes;
	logic [63:0] key_lo_p = '0;
	logic [63:0] key_hi_p = '0;
	logic [7:0]  msg_len;
	logic        in_message;

	siphash_2_4_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic sip_state_t mix_round(input sip_state_t s);
		s.a = s.a + s.b;
		s.b = rotl(s.b, 13) ^ s.a;
		s.a = rotl(s.a, 32);
		s.c = s.c + s.d;
		s.d = rotl(s.d, 16) ^ s.c;
		s.a = s.a + s.d;
		s.d = rotl(s.d, 21) ^ s.a;
		s.c = s.c + s.b;
		s.b = rotl(s.b, 17) ^ s.c;
		s.c = rotl(s.c, 32);
		return s;
	endfunction

	function automatic sip_state_t compress(input sip_state_t s, input logic [63:0] w);
		s.d = s.d ^ w;
		s = mix_round(mix_round(s));
		s.a = s.a ^ w;
		return s;
	endfunction

	// restart the chain from the current key
	task reload_lanes();
		lanes.a    = key_lo_p ^ SIP_IV0;
		lanes.b    = key_hi_p ^ SIP_IV1;
		lanes.c    = key_lo_p ^ SIP_IV2;
		lanes.d    = key_hi_p ^ SIP_IV3;
		msg_len    = '0;
		in_message = 1'b0;
	endtask

	// advance the chain by one accepted word, queue the hash at message end
	task hash_word(input logic [63:0] w, input logic [3:0] count_in, input logic fin);
		logic [3:0]  count;
		logic [63:0] tail;
		count = (count_in > SIP_WORD_BYTES) ? SIP_WORD_BYTES : count_in;
		if (!fin) begin
			lanes      = compress(lanes, w);
			msg_len    = msg_len + 8'd8;
			in_message = 1'b1;
		end else begin
			if (count == SIP_WORD_BYTES) begin
				lanes   = compress(lanes, w);
				msg_len = msg_len + 8'd8;
				tail    = '0;
			end else begin
				tail    = (count == 0) ? 64'd0 : (w & ((64'd1 << (count * 8)) - 64'd1));
				msg_len = msg_len + 8'(count);
			end
			tail  = tail | (64'(msg_len) << SIP_LEN_SHIFT);
			lanes = compress(lanes, tail);
			lanes.c = lanes.c ^ SIP_FINAL_XOR;
			repeat (4) lanes = mix_round(lanes);
			hashes_due.push_back(lanes.a ^ lanes.b ^ lanes.c ^ lanes.d);
			reload_lanes();
		end
	endtask

	task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// ---------------- driver and monitors ----------------

	// offer the next word, or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {4'b0000, next_word.byte_count, next_word.data_word};
				s_tlast  <= next_word.last_word;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// stall the hash output at random
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			hash_word(s_tdata[63:0], s_tdata[67:64], s_tlast);
	end

	// check every hash taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hashes_due.size() == 0)
				report_mismatch("unexpected hash", m_tdata, '0);
			else if (m_tdata !== hashes_due[0])
				report_mismatch("hash_value", m_tdata, hashes_due.pop_front());
			else
				void'(hashes_due.pop_front());
		end
	end

	// ---------------- stimulus ----------------

	task push_word(input logic [63:0] data, input logic [3:0] count, input logic fin);
		msg_word_t w;
		w.data_word  = data;
		w.byte_count = count;
		w.last_word  = fin;
		pending_words.push_back(w);
	endtask

	// hold until every word is taken, the core is idle and every hash is out;
	// sample at the falling edge so all registered values have settled
	task settle();
		while (pending_words.size() != 0 || s_tvalid || !s_tready
			|| hashes_due.size() != 0 || m_tvalid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task write_key(input logic reg_sel, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_KEY_LOW)
			key_lo_p = value;
		else
			key_hi_p = value;
		if (!in_message)
			reload_lanes();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one message: mostly well-formed, some long enough to wrap the length byte,
	// some with short or oversized byte counts
	task add_message(inout int words);
		int n_body;
		int pick;
		logic [3:0] count;
		pick = $urandom_range(99);
		if (pick < 10)
			n_body = $urandom_range(40, 32);
		else if (pick < 25)
			n_body = 0;
		else
			n_body = $urandom_range(6, 1);
		for (int i = 0; i < n_body; i++) begin
			count = ($urandom_range(99) < 10) ? 4'($urandom_range(15)) : SIP_WORD_BYTES;
			push_word(rand64(), count, 1'b0);
		end
		count = ($urandom_range(99) < 15) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
		push_word(rand64(), count, 1'b1);
		words += n_body + 1;
	endtask

	initial begin
		int words;
		reload_lanes();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: standard key, short and full final words
		write_key(REG_KEY_LOW,  64'h0706050403020100);
		write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		push_word(64'h0, 4'd0, 1'b1);
		push_word('1, SIP_WORD_BYTES, 1'b1);
		push_word('1, 4'd7, 1'b1);
		push_word(64'h0706050403020100, 4'd1, 1'b1);
		// short body word absorbed whole, oversized final count
		push_word(rand64(), 4'd3, 1'b0);
		push_word(rand64(), 4'd15, 1'b1);
		push_word(64'h0, SIP_WORD_BYTES, 1'b0);
		push_word('1, SIP_WORD_BYTES, 1'b0);
		push_word(rand64(), 4'd4, 1'b1);
		push_word(rand64(), 4'd9, 1'b0);
		push_word(rand64(), 4'd0, 1'b0);
		push_word(rand64(), SIP_WORD_BYTES, 1'b1);
		// key written mid-message applies from the next message
		push_word(rand64(), SIP_WORD_BYTES, 1'b0);
		settle();
		write_key(REG_KEY_LOW, '1);
		push_word(rand64(), 4'd6, 1'b1);
		push_word(rand64(), 4'd5, 1'b1);
		settle();
		// key written while idle applies at once
		write_key(REG_KEY_HIGH, '1);
		push_word(rand64(), 4'd2, 1'b1);
		push_word(rand64(), 4'd8, 1'b1);
		settle();

		// random: three idling modes, three key settings each
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 45 : 0;
			recv_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 10 : 0;
			for (int batch = 0; batch < 3; batch++) begin
				case (mode * 3 + batch)
					0: begin
						write_key(REG_KEY_LOW, '0);
						write_key(REG_KEY_HIGH, '0);
					end
					1: begin
						write_key(REG_KEY_LOW, '1);
						write_key(REG_KEY_HIGH, '1);
					end
					2: begin
						write_key(REG_KEY_LOW, '0);
						write_key(REG_KEY_HIGH, '1);
					end
					3: begin
						write_key(REG_KEY_LOW, '1);
						write_key(REG_KEY_HIGH, '0);
					end
					default: begin
						write_key(REG_KEY_LOW, rand64());
						write_key(REG_KEY_HIGH, rand64());
					end
				endcase
				words = 0;
				while (words < BATCH_WORDS)
					add_message(words);
				settle();
			end
		end

		if (hashes_due.size() != 0)
			report_mismatch("hash never produced", '0, hashes_due[0]);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
